// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/bpk_pkg.sv =====
package bpk_pkg;

	localparam int DEF_ADDR_BITS = 16;

	// command codes
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_APPEND = 1'b1;

	localparam logic [3:0] FULL_BITS = 4'd8;

	typedef struct packed {
		logic        cmd;
		logic [15:0] base_addr;
		logic [7:0]  data_byte;
		logic        block_end;
		logic [3:0]  valid_bits;
	} item_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  data;
		logic        last;
	} wr_t;

	typedef struct packed {
		logic [1:0] nres;
		wr_t        w0;
		wr_t        w1;
	} pack_res_t;

endpackage

// ===== rtl/bpk_pack.sv =====
module bpk_pack
	import bpk_pkg::*;
#(
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  item_t                 item,
	input  logic [ADDR_BITS-1:0]  ptr_q,
	input  logic [2:0]            off_q,
	input  logic [7:0]            held_q,
	output logic [ADDR_BITS-1:0]  nxt_ptr,
	output logic [2:0]            nxt_off,
	output logic [7:0]            nxt_held,
	output pack_res_t             res
);

	logic [3:0]           n;
	logic [15:0]          mask_wide;
	logic [7:0]           dm;
	logic [15:0]          wide;
	logic [7:0]           first;
	logic [7:0]           spill;
	logic [3:0]           total;
	logic [3:0]           spill_cnt;
	logic [ADDR_BITS-1:0] ptr_inc;
	logic [31:0]          ptr_ext;
	logic [31:0]          inc_ext;
	logic [31:0]          base_ext;

	always_comb begin
		// valid bit count; a byte that does not end the block, or an out of range count, means a full byte
		if (item.block_end && item.valid_bits >= 4'd1 && item.valid_bits <= FULL_BITS) begin
			n = item.valid_bits;
		end else begin
			n = FULL_BITS;
		end
		mask_wide = 16'hFF00 >> n;
		dm        = item.data_byte & mask_wide[7:0];
		wide      = {dm, 8'h00} >> off_q;
		first     = held_q | wide[15:8];
		spill     = wide[7:0];
		total     = {1'b0, off_q} + n;
		spill_cnt = total - FULL_BITS;
		ptr_inc   = ptr_q + ADDR_BITS'(1);
		ptr_ext   = 32'(ptr_q);
		inc_ext   = 32'(ptr_inc);
		base_ext  = 32'(item.base_addr);

		res.w0.addr = ptr_ext[15:0];
		res.w0.data = first;
		res.w0.last = 1'b1;
		res.w1.addr = inc_ext[15:0];
		res.w1.data = spill;
		res.w1.last = 1'b1;

		if (item.cmd == CMD_START) begin
			res.nres = 2'd0;
			nxt_ptr  = base_ext[ADDR_BITS-1:0];
			nxt_off  = 3'd0;
			nxt_held = 8'h00;
		end else if (total > FULL_BITS) begin
			// bits spill into the next byte
			res.nres    = 2'd2;
			res.w0.last = 1'b0;
			nxt_ptr     = ptr_inc;
			nxt_off     = spill_cnt[2:0];
			nxt_held    = spill;
		end else if (total == FULL_BITS) begin
			res.nres = 2'd1;
			nxt_ptr  = ptr_inc;
			nxt_off  = 3'd0;
			nxt_held = 8'h00;
		end else begin
			res.nres = 2'd1;
			nxt_ptr  = ptr_q;
			nxt_off  = total[2:0];
			nxt_held = first;
		end
	end

endmodule

// ===== rtl/msb_first_bit_packer.sv =====
// an accepted input transaction is registered, then packed into the output queue
// throughput: one input transaction per cycle while each causes a single write and the
//   output does not stall; a spilling transaction makes two writes on the single output port
// reset: arst_n clears the write pointer, bit offset, held byte and all valid flags at once
`include "assert_macros.svh"

module msb_first_bit_packer
	import bpk_pkg::*;
#(
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [15:0] base_addr,
	input  logic [7:0]  data_byte,
	input  logic        block_end,
	input  logic [3:0]  valid_bits,
	// byte write channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] wr_addr,
	output logic [7:0]  wr_data,
	output logic        run_last
);

	// input register
	logic  v_s1;
	item_t item_s1;

	// packing state
	logic [ADDR_BITS-1:0] ptr_q;
	logic [2:0]           off_q;
	logic [7:0]           held_q;

	logic [ADDR_BITS-1:0] nxt_ptr;
	logic [2:0]           nxt_off;
	logic [7:0]           nxt_held;
	pack_res_t            res;

	// two-entry output queue, slot0 is the one shown on the port
	logic [1:0] cnt_q;
	wr_t        slot0_q;
	wr_t        slot1_q;

	logic       accept;
	logic       pop;
	logic       fire;
	logic [1:0] rem;
	logic [2:0] room_need;
	wr_t        e0;
	wr_t        e1;
	wr_t        slot0_n;
	wr_t        slot1_n;
	logic [1:0] push_cnt;

	bpk_pack #(
		.ADDR_BITS (ADDR_BITS)
	) u_pack (
		.item     (item_s1),
		.ptr_q    (ptr_q),
		.off_q    (off_q),
		.held_q   (held_q),
		.nxt_ptr  (nxt_ptr),
		.nxt_off  (nxt_off),
		.nxt_held (nxt_held),
		.res      (res)
	);

	always_comb begin
		// entries left once the head transaction is taken this cycle
		pop       = out_valid && !out_stall;
		rem       = cnt_q - {1'b0, pop};
		room_need = {1'b0, rem} + {1'b0, res.nres};
		// the registered item is packed only when all its writes fit in the queue
		fire      = v_s1 && (room_need <= 3'd2);
		in_stall  = v_s1 && !fire;
		accept    = in_valid && !in_stall;
		push_cnt  = fire ? res.nres : 2'd0;

		// compact the queue after a pop
		e0 = pop ? slot1_q : slot0_q;
		e1 = slot1_q;

		// append new writes behind what is left
		slot0_n = (rem != 2'd0) ? e0 : res.w0;
		if (rem == 2'd2) begin
			slot1_n = e1;
		end else if (rem == 2'd1) begin
			slot1_n = res.w0;
		end else begin
			slot1_n = res.w1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			cnt_q  <= 2'd0;
			ptr_q  <= '0;
			off_q  <= 3'd0;
			held_q <= 8'h00;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			cnt_q <= rem + push_cnt;
			if (fire) begin
				ptr_q  <= nxt_ptr;
				off_q  <= nxt_off;
				held_q <= nxt_held;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd        <= cmd;
			item_s1.base_addr  <= base_addr;
			item_s1.data_byte  <= data_byte;
			item_s1.block_end  <= block_end;
			item_s1.valid_bits <= valid_bits;
		end
		slot0_q <= slot0_n;
		slot1_q <= slot1_n;
	end

	assign out_valid = (cnt_q != 2'd0);
	assign wr_addr   = slot0_q.addr;
	assign wr_data   = slot0_q.data;
	assign run_last  = slot0_q.last;

	// queue never holds more than two writes
	`ASSERT_IMPLIES(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= 2'd2)
	// a packed transaction always finds room for its writes
	`ASSERT_IMPLIES(a_room, clk, arst_n, fire, room_need <= 3'd2)
	// bits of the held byte past the offset stay zero
	`ASSERT_IMPLIES(a_held_clean, clk, arst_n, 1'b1, (held_q & (8'hFF >> off_q)) == 8'h00)
	// a start transaction leaves an empty partial byte
	`ASSERT_NEXT(a_start_clr, clk, arst_n, fire && item_s1.cmd == CMD_START,
		off_q == 3'd0 && held_q == 8'h00)

endmodule
